### design/bcu_pkg.sv
// Shared types and constants for the binomial coefficient unit.
package bcu_pkg;

	// Field widths.
	localparam int NW = 6;
	localparam int CW = 64;

	// Result status codes.
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_PAIR = 1'b1;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load;
		logic step;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad;
		logic zero_n;
		logic last;
	} dp_stat_t;

endpackage

### design/bcu_ctrl.sv
// Controller: takes one request, runs the row updates it needs, then holds the result.
module bcu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bcu_pkg::dp_stat_t stat,
	output bcu_pkg::dp_cmd_t  cmd
);

	bcu_pkg::state_t state_q;
	bcu_pkg::state_t state_d;
	logic            accept;

	assign in_ready  = (state_q == bcu_pkg::ST_IDLE);
	assign out_valid = (state_q == bcu_pkg::ST_OUT);
	assign accept    = in_valid && in_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		unique case (state_q)
			bcu_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					cmd.load    = !stat.bad;
					if (stat.bad || stat.zero_n) begin
						state_d = bcu_pkg::ST_OUT;
					end else begin
						state_d = bcu_pkg::ST_RUN;
					end
				end
			end
			bcu_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = bcu_pkg::ST_OUT;
				end
			end
			bcu_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = bcu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bcu_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/bcu_datapath.sv
// Datapath: a row of adders that advances a shifted Pascal row once per cycle.
// The row is held so that the wanted entry always ends at position 0: it starts
// as a single one at position n-k, and each step adds every entry's upper
// neighbor into it. After n steps position 0 holds C(n,k).
module bcu_datapath #(
	parameter int MAX_N = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bcu_pkg::dp_cmd_t           cmd,
	output bcu_pkg::dp_stat_t          stat,
	input  logic [bcu_pkg::NW-1:0]     row_n,
	input  logic [bcu_pkg::NW-1:0]     choose_k,
	output logic [bcu_pkg::CW-1:0]     coefficient,
	output logic                       status
);

	localparam int DEPTH = MAX_N + 1;

	logic [bcu_pkg::CW-1:0] row_q [DEPTH];
	logic [bcu_pkg::NW-1:0] steps_q;
	logic                   bad_q;
	logic [bcu_pkg::NW-1:0] offset;
	logic                   bad;

	// Request checks on the incoming pair.
	assign offset = row_n - choose_k;
	assign bad    = (choose_k > row_n) || (int'(row_n) > MAX_N);

	assign stat.bad    = bad;
	assign stat.zero_n = (row_n == '0);
	assign stat.last   = (steps_q == bcu_pkg::NW'(1));

	// Row cells: one adder per entry, the top entry adds zero.
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [bcu_pkg::CW-1:0] upper;
		if (j < DEPTH - 1) begin : g_mid
			assign upper = row_q[j+1];
		end else begin : g_top
			assign upper = '0;
		end

		always_ff @(posedge clk) begin
			if (cmd.load) begin
				row_q[j] <= (j == int'(offset)) ? bcu_pkg::CW'(1) : '0;
			end else if (cmd.step) begin
				row_q[j] <= row_q[j] + upper;
			end
		end
	end

	// Step counter and request status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			bad_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				steps_q <= row_n;
				bad_q   <= bad;
			end else if (cmd.step) begin
				steps_q <= steps_q - bcu_pkg::NW'(1);
			end
		end
	end

	// A refused request reports zero.
	assign coefficient = bad_q ? '0 : row_q[0];
	assign status      = bad_q ? bcu_pkg::STATUS_BAD_PAIR : bcu_pkg::STATUS_OK;

endmodule

### design/binomial_coefficient_unit.sv
// Binomial coefficient unit: returns C(n,k) as an exact 64-bit integer.
// Input channel: in_valid/in_ready with row_n (n) and choose_k (k), 6 bits each.
// Output channel: out_valid/out_ready with coefficient and status.
// status is 1 when k is greater than n (or n is above MAX_N); coefficient is 0.
// One request is in flight at a time. A valid request runs n row updates,
// one shifted Pascal row per cycle through MAX_N+1 parallel 64-bit adders,
// before its result shows; a request with n = 0 or a refused request goes
// straight to the result. in_ready returns in the cycle after the result
// is taken. The result is held in place while out_ready is low; no new
// request is taken until it is delivered.
// Reset (arst_n low) returns the controller to idle with no result pending;
// the row store needs no clearing since each valid request loads it first.
module binomial_coefficient_unit #(
	parameter int MAX_N = 63
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [bcu_pkg::NW-1:0] row_n,
	input  logic [bcu_pkg::NW-1:0] choose_k,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [bcu_pkg::CW-1:0] coefficient,
	output logic                   status
);

	bcu_pkg::dp_cmd_t  cmd;
	bcu_pkg::dp_stat_t stat;

	bcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bcu_datapath #(
		.MAX_N (MAX_N)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.row_n       (row_n),
		.choose_k    (choose_k),
		.coefficient (coefficient),
		.status      (status)
	);

endmodule

### design/bcu_checker.sv
// Port-level checks for the binomial coefficient unit.
module bcu_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [bcu_pkg::NW-1:0] row_n,
	input logic [bcu_pkg::NW-1:0] choose_k,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [bcu_pkg::CW-1:0] coefficient,
	input logic                   status
);

	// A refused request always reports a zero coefficient.
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bcu_pkg::STATUS_BAD_PAIR) |-> coefficient == '0)
		else $error("refused request with nonzero coefficient");

	// The unit never takes a request while a result is pending.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request taken while a result is pending");

	// A pair with k above n is answered in the next cycle as refused.
	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (choose_k > row_n)
		|=> out_valid && (status == bcu_pkg::STATUS_BAD_PAIR))
		else $error("k above n not refused in the next cycle");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(status))
		else $error("stalled result changed");

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.row_n       (row_n),
	.choose_k    (choose_k),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.coefficient (coefficient),
	.status      (status)
);
